// ----- rtl/ppti_pkg.sv -----
// Shared constants, types and tables of the pair potential table interpolator.
`default_nettype none
package ppti_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned TYPE_PAIRS    = 64;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned R2_W      = 24;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned PROD_W    = R2_W + SCALE_W;
  localparam int unsigned IDX_W     = PROD_W - FRAC_W;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned PAIR_IN_W = 6;
  localparam int unsigned PAIR_IN_N = 1 << PAIR_IN_W;
  localparam int unsigned ENTRY_IN_W = 12;

  localparam int unsigned PAIR_W  = (TYPE_PAIRS > 1) ? $clog2(TYPE_PAIRS) : 1;
  localparam int unsigned ENTRY_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned DEPTH   = TYPE_PAIRS * TABLE_ENTRIES;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);

  localparam int unsigned DIFF_W  = DATA_W + 1;
  localparam int unsigned WGT_W   = FRAC_W + 1;
  localparam int unsigned MUL_W   = DIFF_W + WGT_W;

  localparam logic [WGT_W-1:0] WGT_ONE  = WGT_W'(1) << FRAC_W;
  localparam logic [WGT_W-1:0] WGT_HALF = WGT_W'(1) << (FRAC_W - 1);

  localparam logic [OP_W-1:0] OP_INTERP = 2'd0;
  localparam logic [OP_W-1:0] OP_FAST   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

  localparam logic CFG_SCALE_FACTOR = 1'b0;
  localparam logic CFG_ENERGY_CAP   = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd8192;
  localparam logic [DATA_W-1:0]  CAP_RESET   = 32'h7FFF_FFFF;

  typedef logic [PAIR_W-1:0] pair_t;
  typedef pair_t [PAIR_IN_N-1:0] pair_map_t;

  function automatic pair_map_t pair_map_init();
    pair_map_t m;
    for (int k = 0; k < PAIR_IN_N; k++) begin
      m[k] = PAIR_W'(k % TYPE_PAIRS);
    end
    return m;
  endfunction

  localparam pair_map_t PAIR_MAP = pair_map_init();

endpackage
`default_nettype wire

// ----- rtl/ppti_ram.sv -----
// Generic RAM: one write port, two registered read ports, read-first.
`default_nettype none
module ppti_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pair_potential_table_interp.sv -----
// Top level of the pair potential table interpolator.
//
// Command channel: an item is taken at each rising edge with start_i high and
// busy_o low; busy_o stays low, so one item can enter every cycle.
// operation_i selects interpolating evaluate, fast evaluate or table load.
// A load writes one energy/slope point (energy capped at energy_cap) and gives
// no result. Each evaluation gives one result beat on energy_o, slope_o and
// clamped_o, marked by valid_o for exactly one cycle. Throughput is one item
// per cycle: the two-read-port table RAM fetches points i and i+1 together
// and the two blend multipliers are pipelined. A load writes its point
// before any later evaluation reads the table, so an evaluation sees every
// earlier load.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 scale_factor, 1 energy_cap) at the clock edge; write only when idle.
// Reset clears the pipeline valid bits and restores the registers; the table
// contents stay undefined until loaded. The receiver cannot stall results.
`default_nettype none
module pair_potential_table_interp (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     start_i,
  output logic                                          busy_o,
  input  wire logic        [ppti_pkg::OP_W-1:0]         operation_i,
  input  wire logic        [ppti_pkg::PAIR_IN_W-1:0]    pair_index_i,
  input  wire logic        [ppti_pkg::ENTRY_IN_W-1:0]   entry_index_i,
  input  wire logic        [ppti_pkg::R2_W-1:0]         r_squared_i,
  input  wire logic signed [ppti_pkg::DATA_W-1:0]       entry_energy_i,
  input  wire logic signed [ppti_pkg::DATA_W-1:0]       entry_slope_i,
  input  wire logic                                     cfg_we_i,
  input  wire logic                                     cfg_index_i,
  input  wire logic        [ppti_pkg::DATA_W-1:0]       cfg_wdata_i,
  output logic                                          valid_o,
  output logic signed      [ppti_pkg::DATA_W-1:0]       energy_o,
  output logic signed      [ppti_pkg::DATA_W-1:0]       slope_o,
  output logic                                          clamped_o
);

  localparam int unsigned DW = ppti_pkg::DATA_W;
  localparam int unsigned AW = ppti_pkg::ADDR_W;
  localparam int unsigned FW = ppti_pkg::FRAC_W;

  logic [ppti_pkg::SCALE_W-1:0] scale_factor_q;
  logic signed [DW-1:0]         energy_cap_q;

  logic accept;
  logic is_eval;
  logic is_load;
  logic entry_ok;
  logic [AW-1:0] base_d;
  logic signed [DW-1:0] capped_energy;

  // stage 1
  logic                    ev1_q, ld1_q, fast1_q;
  logic [ppti_pkg::PROD_W-1:0] prod1_q;
  logic [AW-1:0]           base1_q;
  logic [AW-1:0]           entry1_q;
  logic [DW-1:0]           wen1_q, wsl1_q;

  // stage 2
  logic [ppti_pkg::IDX_W-1:0] idx2;
  logic [ppti_pkg::IDX_W:0]   idx_inc2;
  logic                       clamp2;
  logic [ppti_pkg::ENTRY_W-1:0] idx_c2;
  logic                       ev2_q, fast2_q, clamp2_q;
  logic [ppti_pkg::WGT_W-1:0] wgt2_q;
  logic [AW-1:0]              raddr_a_q, raddr_b_q;

  // stage 3 (RAM output)
  logic                       ev3_q, fast3_q, clamp3_q;
  logic [ppti_pkg::WGT_W-1:0] wgt3_q;
  logic [2*DW-1:0]            rd_a, rd_b;
  logic signed [DW-1:0]       e_a, e_b, s_a, s_b;

  // stage 4
  logic                         ev4_q, clamp4_q;
  logic [ppti_pkg::WGT_W-1:0]   wgt4_q;
  logic signed [DW-1:0]         ae4_q, as4_q;
  logic signed [ppti_pkg::DIFF_W-1:0] de4_q, ds4_q;

  // stage 5
  logic                         ev5_q, clamp5_q;
  logic signed [DW-1:0]         ae5_q, as5_q;
  logic signed [ppti_pkg::MUL_W-1:0] pe5_q, ps5_q;
  logic signed [ppti_pkg::MUL_W-1:0] pe5_d, ps5_d;

  // output
  logic signed [ppti_pkg::DIFF_W:0] e_sum, s_sum;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign is_eval = (operation_i == ppti_pkg::OP_INTERP) || (operation_i == ppti_pkg::OP_FAST);
  assign entry_ok = 32'(entry_index_i) < 32'(ppti_pkg::TABLE_ENTRIES);
  assign is_load = (operation_i == ppti_pkg::OP_LOAD) && entry_ok;
  assign base_d  = AW'(ppti_pkg::PAIR_MAP[pair_index_i]) * AW'(ppti_pkg::TABLE_ENTRIES);
  assign capped_energy = (entry_energy_i > energy_cap_q) ? energy_cap_q : entry_energy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_factor_q <= ppti_pkg::SCALE_RESET;
      energy_cap_q   <= ppti_pkg::CAP_RESET;
      ev1_q <= 1'b0;
      ld1_q <= 1'b0;
      ev2_q <= 1'b0;
      ev3_q <= 1'b0;
      ev4_q <= 1'b0;
      ev5_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ppti_pkg::CFG_SCALE_FACTOR: scale_factor_q <= cfg_wdata_i[ppti_pkg::SCALE_W-1:0];
          ppti_pkg::CFG_ENERGY_CAP:   energy_cap_q   <= cfg_wdata_i;
        endcase
      end
      ev1_q   <= accept && is_eval;
      ld1_q   <= accept && is_load;
      ev2_q   <= ev1_q;
      ev3_q   <= ev2_q;
      ev4_q   <= ev3_q;
      ev5_q   <= ev4_q;
      valid_o <= ev5_q;
    end
  end

  // stage 2 index and clamp
  assign idx2     = prod1_q[ppti_pkg::PROD_W-1:FW];
  assign idx_inc2 = {1'b0, idx2} + (ppti_pkg::IDX_W+1)'(1);
  assign clamp2   = idx_inc2 >= (ppti_pkg::IDX_W+1)'(ppti_pkg::TABLE_ENTRIES);
  assign idx_c2   = clamp2 ? ppti_pkg::ENTRY_W'(ppti_pkg::TABLE_ENTRIES - 2)
                           : ppti_pkg::ENTRY_W'(idx2);

  assign e_a = $signed(rd_a[2*DW-1:DW]);
  assign s_a = $signed(rd_a[DW-1:0]);
  assign e_b = $signed(rd_b[2*DW-1:DW]);
  assign s_b = $signed(rd_b[DW-1:0]);

  assign pe5_d = de4_q * $signed({1'b0, wgt4_q});
  assign ps5_d = ds4_q * $signed({1'b0, wgt4_q});

  assign e_sum = (ppti_pkg::DIFF_W+1)'(ae5_q) + (ppti_pkg::DIFF_W+1)'(pe5_q >>> FW);
  assign s_sum = (ppti_pkg::DIFF_W+1)'(as5_q) + (ppti_pkg::DIFF_W+1)'(ps5_q >>> FW);

  always_ff @(posedge clk_i) begin
    fast1_q  <= operation_i == ppti_pkg::OP_FAST;
    prod1_q  <= ppti_pkg::PROD_W'(r_squared_i) * ppti_pkg::PROD_W'(scale_factor_q);
    base1_q  <= base_d;
    entry1_q <= AW'(entry_index_i);
    wen1_q   <= capped_energy;
    wsl1_q   <= entry_slope_i;

    fast2_q   <= fast1_q;
    clamp2_q  <= clamp2;
    wgt2_q    <= clamp2 ? ppti_pkg::WGT_ONE : ppti_pkg::WGT_W'(prod1_q[FW-1:0]);
    raddr_a_q <= base1_q + AW'(idx_c2);
    raddr_b_q <= base1_q + AW'(idx_c2) + AW'(1);

    fast3_q  <= fast2_q;
    clamp3_q <= clamp2_q;
    wgt3_q   <= wgt2_q;

    // fast mode: zero base, sum as difference, half weight
    clamp4_q <= clamp3_q;
    if (fast3_q) begin
      wgt4_q <= ppti_pkg::WGT_HALF;
      ae4_q  <= '0;
      as4_q  <= '0;
      de4_q  <= ppti_pkg::DIFF_W'(e_a) + ppti_pkg::DIFF_W'(e_b);
      ds4_q  <= '0;
    end else begin
      wgt4_q <= wgt3_q;
      ae4_q  <= e_a;
      as4_q  <= s_a;
      de4_q  <= ppti_pkg::DIFF_W'(e_b) - ppti_pkg::DIFF_W'(e_a);
      ds4_q  <= ppti_pkg::DIFF_W'(s_b) - ppti_pkg::DIFF_W'(s_a);
    end

    clamp5_q <= clamp4_q;
    ae5_q    <= ae4_q;
    as5_q    <= as4_q;
    pe5_q    <= pe5_d;
    ps5_q    <= ps5_d;

    energy_o  <= e_sum[DW-1:0];
    slope_o   <= s_sum[DW-1:0];
    clamped_o <= clamp5_q;
  end

  ppti_ram #(
    .WIDTH (2 * DW),
    .DEPTH (ppti_pkg::DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ld1_q),
    .waddr_i   (base1_q + entry1_q),
    .wdata_i   ({wen1_q, wsl1_q}),
    .raddr_a_i (raddr_a_q),
    .raddr_b_i (raddr_b_q),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

endmodule
`default_nettype wire

// ----- rtl/ppti_checker.sv -----
// Port-level checker of the pair potential table interpolator and its bind.
`default_nettype none
module ppti_checker (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   start_i,
  input wire logic                                   busy_o,
  input wire logic        [ppti_pkg::OP_W-1:0]       operation_i,
  input wire logic                                   valid_o,
  input wire logic signed [ppti_pkg::DATA_W-1:0]     slope_o
);

  logic eval_beat;
  logic fast_beat;
  logic other_beat;

  assign eval_beat  = start_i && !busy_o &&
                      (operation_i == ppti_pkg::OP_INTERP || operation_i == ppti_pkg::OP_FAST);
  assign fast_beat  = start_i && !busy_o && operation_i == ppti_pkg::OP_FAST;
  assign other_beat = start_i && !busy_o && !eval_beat;

  a_eval_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_beat |-> ##6 valid_o)
    else $error("evaluation beat gave no result");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(eval_beat, 6))
    else $error("result without evaluation beat");

  a_no_result_for_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    other_beat |-> ##6 !valid_o)
    else $error("load or unused operation gave a result");

  a_fast_zero_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(fast_beat, 6) |-> slope_o == '0)
    else $error("fast evaluation returned non-zero slope");

endmodule

bind pair_potential_table_interp ppti_checker u_ppti_checker (.*);
`default_nettype wire

// ----- dv/pair_potential_table_interp_tb.sv -----
// Self-checking testbench for the pair potential table interpolator.
module pair_potential_table_interp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppti_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PIPE_SETTLE = 12;
  localparam int unsigned ITEMS_PER_PHASE = 100;

  typedef struct {
    logic signed [DATA_W-1:0] energy;
    logic signed [DATA_W-1:0] slope;
    logic                     clamped;
  } potential_t;

  class pair_table_tracker;
    logic signed [DATA_W-1:0] energy_at [int unsigned];
    logic signed [DATA_W-1:0] slope_at [int unsigned];
    logic [SCALE_W-1:0]       scale;
    logic signed [DATA_W-1:0] cap;
    potential_t               results_due [$];
    int unsigned              mismatches;

    function new();
      scale      = SCALE_RESET;
      cap        = CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [DATA_W-1:0] value);
      if (idx == CFG_SCALE_FACTOR) begin
        scale = value[SCALE_W-1:0];
      end else begin
        cap = value;
      end
    endfunction

    function int unsigned address(logic [PAIR_IN_W-1:0] pair, int unsigned idx);
      return (int'(pair) % TYPE_PAIRS) * TABLE_ENTRIES + idx;
    endfunction

    function bit holds(logic [PAIR_IN_W-1:0] pair, int unsigned idx);
      return energy_at.exists(address(pair, idx));
    endfunction

    function void locate(input logic [R2_W-1:0] r2, output int unsigned idx,
                         output longint frac, output bit clamp);
      longint unsigned prod;
      prod  = 64'(r2) * 64'(scale);
      idx   = int'(prod >> FRAC_W);
      frac  = longint'(prod & ((64'd1 << FRAC_W) - 1));
      clamp = 1'b0;
      if (idx + 1 >= TABLE_ENTRIES) begin
        idx   = TABLE_ENTRIES - 2;
        frac  = longint'(64'd1 << FRAC_W);
        clamp = 1'b1;
      end
    endfunction

    function longint blend(longint a, longint b, longint frac);
      return a + (((b - a) * frac) >>> FRAC_W);
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [PAIR_IN_W-1:0] pair,
                               logic [ENTRY_IN_W-1:0] entry, logic [R2_W-1:0] r2,
                               logic signed [DATA_W-1:0] e_in,
                               logic signed [DATA_W-1:0] s_in);
      int unsigned idx;
      int unsigned lo;
      int unsigned hi;
      longint      frac;
      bit          clamp;
      longint      e1;
      longint      e2;
      longint      s1;
      longint      s2;
      potential_t  res;
      case (op)
        OP_LOAD: begin
          if (entry < TABLE_ENTRIES) begin
            energy_at[address(pair, entry)] = (e_in > cap) ? cap : e_in;
            slope_at[address(pair, entry)]  = s_in;
          end
        end
        OP_INTERP, OP_FAST: begin
          locate(r2, idx, frac, clamp);
          lo = address(pair, idx);
          hi = address(pair, idx + 1);
          e1 = energy_at[lo];
          e2 = energy_at[hi];
          s1 = slope_at[lo];
          s2 = slope_at[hi];
          res.clamped = clamp;
          if (op == OP_INTERP) begin
            res.energy = DATA_W'(blend(e1, e2, frac));
            res.slope  = DATA_W'(blend(s1, s2, frac));
          end else begin
            res.energy = DATA_W'((e1 + e2) >>> 1);
            res.slope  = '0;
          end
          results_due.push_back(res);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_beat(logic signed [DATA_W-1:0] e, logic signed [DATA_W-1:0] s,
                             logic c);
      potential_t want;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result energy %h slope %h clamped %b", $time, e, s, c);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      if (e !== want.energy) begin
        $display("%0t: energy expected %h actual %h", $time, want.energy, e);
        mismatches++;
      end
      if (s !== want.slope) begin
        $display("%0t: slope expected %h actual %h", $time, want.slope, s);
        mismatches++;
      end
      if (c !== want.clamped) begin
        $display("%0t: clamped expected %b actual %b", $time, want.clamped, c);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         start_i        = 1'b0;
  logic                         busy_o;
  logic        [OP_W-1:0]       operation_i    = '0;
  logic        [PAIR_IN_W-1:0]  pair_index_i   = '0;
  logic        [ENTRY_IN_W-1:0] entry_index_i  = '0;
  logic        [R2_W-1:0]       r_squared_i    = '0;
  logic signed [DATA_W-1:0]     entry_energy_i = '0;
  logic signed [DATA_W-1:0]     entry_slope_i  = '0;
  logic                         cfg_we_i       = 1'b0;
  logic                         cfg_index_i    = 1'b0;
  logic        [DATA_W-1:0]     cfg_wdata_i    = '0;
  logic                         valid_o;
  logic signed [DATA_W-1:0]     energy_o;
  logic signed [DATA_W-1:0]     slope_o;
  logic                         clamped_o;

  pair_table_tracker tracker = new();
  bit                no_gaps = 1'b0;
  int unsigned       cycles  = 0;
  int unsigned       items_sent = 0;

  pair_potential_table_interp DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .pair_index_i   (pair_index_i),
    .entry_index_i  (entry_index_i),
    .r_squared_i    (r_squared_i),
    .entry_energy_i (entry_energy_i),
    .entry_slope_i  (entry_slope_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .valid_o        (valid_o),
    .energy_o       (energy_o),
    .slope_o        (slope_o),
    .clamped_o      (clamped_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      tracker.check_beat(energy_o, slope_o, clamped_o);
    end
  end

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_command(input logic [OP_W-1:0] op, input logic [PAIR_IN_W-1:0] pair,
                              input logic [ENTRY_IN_W-1:0] entry,
                              input logic [R2_W-1:0] r2,
                              input logic [DATA_W-1:0] e_in,
                              input logic [DATA_W-1:0] s_in);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) begin
      no_gaps = !no_gaps;
    end
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i        <= 1'b1;
    operation_i    <= op;
    pair_index_i   <= pair;
    entry_index_i  <= entry;
    r_squared_i    <= r2;
    entry_energy_i <= e_in;
    entry_slope_i  <= s_in;
    do begin
      @(posedge clk_i);
    end while (busy_o !== 1'b0);
    tracker.note_command(op, pair, entry, r2, e_in, s_in);
    items_sent++;
  endtask

  task automatic evaluate_at(input logic [OP_W-1:0] op, input logic [PAIR_IN_W-1:0] pair,
                             input logic [R2_W-1:0] r2);
    int unsigned idx;
    longint      frac;
    bit          clamp;
    tracker.locate(r2, idx, frac, clamp);
    for (int k = 0; k < 2; k++) begin
      if (!tracker.holds(pair, idx + k)) begin
        send_command(OP_LOAD, pair, ENTRY_IN_W'(idx + k), R2_W'($urandom),
                     random_word(), random_word());
      end
    end
    send_command(op, pair, ENTRY_IN_W'($urandom), r2, $urandom, $urandom);
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  task automatic random_step();
    int unsigned      pick;
    logic [PAIR_IN_W-1:0] pair;
    logic [R2_W-1:0]  r2;
    pick = $urandom_range(0, 99);
    pair = $urandom_range(0, 1) ? PAIR_IN_W'($urandom_range(0, 3)) : PAIR_IN_W'($urandom);
    r2   = R2_W'($urandom) >> $urandom_range(0, R2_W - 1);
    if (pick < 70) begin
      evaluate_at($urandom_range(0, 1) ? OP_FAST : OP_INTERP, pair, r2);
    end else if (pick < 88) begin
      send_command(OP_LOAD, PAIR_IN_W'($urandom), ENTRY_IN_W'($urandom), R2_W'($urandom),
                   random_word(), random_word());
    end else begin
      send_command(OP_NONE, PAIR_IN_W'($urandom), ENTRY_IN_W'($urandom), R2_W'($urandom),
                   $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_command(OP_LOAD, 6'd0, 12'd0, 24'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_command(OP_LOAD, 6'd0, 12'd1, 24'hFFFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_command(OP_INTERP, 6'd0, 12'hFFF, 24'd0, $urandom, $urandom);
    send_command(OP_INTERP, 6'd0, 12'd0, 24'h0003FF, $urandom, $urandom);
    send_command(OP_INTERP, 6'd0, 12'd0, 24'h0007FF, $urandom, $urandom);
    send_command(OP_FAST, 6'd0, 12'd0, 24'h0007FF, $urandom, $urandom);
    send_command(OP_LOAD, 6'h3F, 12'hFFE, 24'd0, $urandom, $urandom);
    send_command(OP_LOAD, 6'h3F, 12'hFFF, 24'd0, 32'hFFFF_FFFF, 32'd1);
    send_command(OP_INTERP, 6'h3F, 12'd0, 24'h7FF000, $urandom, $urandom);
    send_command(OP_INTERP, 6'h3F, 12'd0, 24'h7FF800, $urandom, $urandom);
    send_command(OP_FAST, 6'h3F, 12'd0, 24'hFFFFFF, $urandom, $urandom);
    send_command(OP_INTERP, 6'h3F, 12'd0, 24'hFFFFFF, $urandom, $urandom);
    send_command(OP_NONE, 6'h3F, 12'hFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OP_LOAD, 6'h3F, 12'hFFF, 24'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_command(OP_FAST, 6'h3F, 12'd0, 24'h7FF000, $urandom, $urandom);
    send_command(OP_INTERP, 6'h3F, 12'd0, 24'h7FF7FF, $urandom, $urandom);

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        1: begin
          write_reg(CFG_SCALE_FACTOR, 32'd1);
          write_reg(CFG_ENERGY_CAP, 32'h7FFF_FFFF);
        end
        2: begin
          write_reg(CFG_SCALE_FACTOR, 32'd65535);
          write_reg(CFG_ENERGY_CAP, 32'h8000_0000);
        end
        3: begin
          write_reg(CFG_SCALE_FACTOR, DATA_W'($urandom_range(1, 65535)));
          write_reg(CFG_ENERGY_CAP, $urandom);
        end
        4: begin
          write_reg(CFG_SCALE_FACTOR, 32'd256);
          write_reg(CFG_ENERGY_CAP, 32'd0);
        end
        default: begin
        end
      endcase
      while (items_sent < ITEMS_PER_PHASE * (p + 1)) begin
        random_step();
      end
    end

    settle();
    if (tracker.mismatches == 0 && tracker.results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
